FILE: sv/plk_pkg.sv
package plk_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 7;
  localparam int IDX_IN_W    = 6;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int ACC_W       = DIFF_W + FRAC_BITS;
  localparam int STEP_W      = $clog2(FRAC_BITS);

  // The sentinel is compared at 64 bits so that it never aliases a 32-bit x.
  localparam longint SENTINEL_X = -64'sd999 * (64'sd1 <<< FRAC_BITS);
  localparam logic [DATA_W-1:0] ONE_FIXED = DATA_W'(64'sd1 <<< FRAC_BITS);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_LOW    = 3'd0,
    REG_HIGH   = 3'd1,
    REG_EXACT  = 3'd2,
    REG_INTERP = 3'd3,
    REG_SENT   = 3'd4
  } region_t;

  typedef enum logic {
    AR_DIV = 1'b0,
    AR_MUL = 1'b1
  } arith_mode_t;

  typedef struct packed {
    logic        start;
    arith_mode_t mode;
  } arith_req_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_SCAN = 3'd1,
    ST_PREP = 3'd2,
    ST_DIV  = 3'd3,
    ST_MUL  = 3'd4,
    ST_FIN  = 3'd5
  } state_t;

endpackage

FILE: sv/plk_in_if.sv
interface plk_in_if;
  logic                                valid;
  logic                                ready;
  plk_pkg::op_t                        op;
  logic [plk_pkg::IDX_IN_W-1:0]        entry_index;
  logic signed [plk_pkg::DATA_W-1:0]   x_value;
  logic signed [plk_pkg::DATA_W-1:0]   y_value;

  modport source (output valid, output op, output entry_index, output x_value,
                  output y_value, input ready);
  modport sink (input valid, input op, input entry_index, input x_value,
                input y_value, output ready);
endinterface

FILE: sv/plk_out_if.sv
interface plk_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plk_pkg::DATA_W-1:0]   y_result;
  plk_pkg::region_t                    region;

  modport source (output valid, output y_result, output region, input ready);
  modport sink (input valid, input y_result, input region, output ready);
endinterface

FILE: sv/plk_table.sv
module plk_table (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [plk_pkg::IDX_W-1:0]    wr_addr,
  input  logic [plk_pkg::DATA_W-1:0]   wr_x,
  input  logic [plk_pkg::DATA_W-1:0]   wr_y,
  input  logic [plk_pkg::IDX_W-1:0]    rd_addr,
  output logic [plk_pkg::DATA_W-1:0]   rd_x,
  output logic [plk_pkg::DATA_W-1:0]   rd_y
);

  logic [2*plk_pkg::DATA_W-1:0] mem_r [plk_pkg::TABLE_DEPTH];
  logic [2*plk_pkg::DATA_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_x, wr_y};
    end
    rd_q_r <= mem_r[rd_addr];
  end

  assign rd_x = rd_q_r[2*plk_pkg::DATA_W-1:plk_pkg::DATA_W];
  assign rd_y = rd_q_r[plk_pkg::DATA_W-1:0];

endmodule

FILE: sv/plk_arith.sv
module plk_arith (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plk_pkg::arith_req_t                 req,
  input  logic [plk_pkg::DIFF_W-1:0]          div_num,
  input  logic [plk_pkg::DIFF_W-1:0]          div_den,
  input  logic [plk_pkg::FRAC_BITS-1:0]       mul_f,
  input  logic signed [plk_pkg::DIFF_W-1:0]   mul_dy,
  output logic                                done,
  output logic [plk_pkg::FRAC_BITS-1:0]       quot,
  output logic signed [plk_pkg::ACC_W-1:0]    prod
);

  localparam int AW = plk_pkg::ACC_W;
  localparam int BW = plk_pkg::DIFF_W;
  localparam int FW = plk_pkg::FRAC_BITS;

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [plk_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  plk_pkg::arith_mode_t         mode_r, mode_nxt;
  logic [AW-1:0]                acc_r, acc_nxt;
  logic [BW-1:0]                b_r, b_nxt;
  logic [FW-1:0]                sh_r, sh_nxt;

  logic [AW-1:0] a_sh;
  logic [AW-1:0] b_ext;
  logic [AW-1:0] sum;
  logic          sub;
  logic          take;

  // One shared adder: trial subtract for a divide step, add for a multiply step.
  always_comb begin
    a_sh = {acc_r[AW-2:0], 1'b0};
    sub  = (mode_r == plk_pkg::AR_DIV);
    if (sub) begin
      b_ext = {{(AW-BW){1'b0}}, b_r};
    end else if (sh_r[FW-1]) begin
      b_ext = {{(AW-BW){b_r[BW-1]}}, b_r};
    end else begin
      b_ext = '0;
    end
    sum  = a_sh + (sub ? ~b_ext : b_ext) + AW'(sub);
    take = ~sum[AW-1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    sh_nxt   = sh_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = plk_pkg::STEP_W'(FW - 1);
      mode_nxt = req.mode;
      if (req.mode == plk_pkg::AR_DIV) begin
        acc_nxt = {{(AW-BW){1'b0}}, div_num};
        b_nxt   = div_den;
        sh_nxt  = '0;
      end else begin
        acc_nxt = '0;
        b_nxt   = mul_dy;
        sh_nxt  = mul_f;
      end
    end else if (busy_r) begin
      if (mode_r == plk_pkg::AR_DIV) begin
        acc_nxt = take ? sum : a_sh;
        sh_nxt  = {sh_r[FW-2:0], take};
      end else begin
        acc_nxt = sum;
        sh_nxt  = {sh_r[FW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= plk_pkg::AR_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    sh_r  <= sh_nxt;
  end

  assign done = done_r;
  assign quot = sh_r;
  assign prod = $signed(acc_r);

endmodule

FILE: sv/piecewise_linear_lookup_top.sv
// Piecewise linear lookup over a table of up to 64 signed Q16.16 (x, y)
// breakpoints. A write request stores one pair; the block is ready again on
// the next cycle. A query request is worked on alone: the table is scanned
// one entry per cycle through its single read port. A low clamp is answered
// once the first entry is checked; a high clamp, an exact answer or an
// interpolation waits until all entries in use are checked. An interpolated
// answer then has one shared 49-bit adder run 16 restoring divide steps for
// the segment fraction followed by 16 shift-add steps for the multiply. The
// sentinel x of -999.0 answers 1.0 without a scan. A finished result waits in
// the output register while further writes are taken. The entry count
// register is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Zero acts as one and values above 64 act as 64. Reading an entry that was
// never written gives an unspecified result.
module piecewise_linear_lookup_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [plk_pkg::CNT_W-1:0]     cfg_wdata,
  plk_in_if.sink                        in_req,
  plk_out_if.source                     out_rsp
);

  localparam int DW = plk_pkg::DATA_W;
  localparam int IW = plk_pkg::IDX_W;
  localparam int FW = plk_pkg::FRAC_BITS;

  plk_pkg::state_t              state_r, state_nxt;
  logic [plk_pkg::CNT_W-1:0]    entry_count_r, entry_count_nxt;
  logic [IW-1:0]                last_r, last_nxt;
  logic [IW-1:0]                rd_idx_r, rd_idx_nxt;
  logic                         iss_done_r, iss_done_nxt;
  logic                         chk_v_r, chk_v_nxt;
  logic [IW-1:0]                chk_idx_r, chk_idx_nxt;
  logic                         match_r, match_nxt;
  logic                         seg_r, seg_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic signed [DW-1:0]         qx_r, qx_nxt;
  logic signed [DW-1:0]         match_y_r, match_y_nxt;
  logic signed [DW-1:0]         prev_x_r, prev_x_nxt;
  logic signed [DW-1:0]         prev_y_r, prev_y_nxt;
  logic signed [DW-1:0]         xl_r, xl_nxt;
  logic signed [DW-1:0]         yl_r, yl_nxt;
  logic signed [DW-1:0]         xh_r, xh_nxt;
  logic signed [DW-1:0]         yh_r, yh_nxt;
  logic signed [DW:0]           dy_r, dy_nxt;
  logic signed [DW-1:0]         res_y_r, res_y_nxt;
  plk_pkg::region_t             res_region_r, res_region_nxt;
  logic signed [DW-1:0]         out_y_r, out_y_nxt;
  plk_pkg::region_t             out_region_r, out_region_nxt;

  logic                         in_acc;
  logic                         wr_en;
  logic [IW-1:0]                last_calc;
  logic [DW-1:0]                rd_x, rd_y;
  logic signed [DW-1:0]         scan_x, scan_y;
  logic signed [DW:0]           dx, diff, dy;

  plk_pkg::arith_req_t          arith_req;
  logic                         arith_done;
  logic [FW-1:0]                arith_quot;
  logic signed [plk_pkg::ACC_W-1:0] arith_prod;

  assign in_req.ready = (state_r == plk_pkg::ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign wr_en        = in_acc && (in_req.op == plk_pkg::OP_WRITE) &&
                        (32'(in_req.entry_index) < plk_pkg::TABLE_DEPTH);

  assign scan_x = $signed(rd_x);
  assign scan_y = $signed(rd_y);
  assign dx     = {xh_r[DW-1], xh_r} - {xl_r[DW-1], xl_r};
  assign diff   = {qx_r[DW-1], qx_r} - {xl_r[DW-1], xl_r};
  assign dy     = {yh_r[DW-1], yh_r} - {yl_r[DW-1], yl_r};

  always_comb begin
    if (entry_count_r == '0) begin
      last_calc = '0;
    end else if (32'(entry_count_r) > plk_pkg::TABLE_DEPTH) begin
      last_calc = IW'(plk_pkg::TABLE_DEPTH - 1);
    end else begin
      last_calc = IW'(entry_count_r - 1'b1);
    end
  end

  plk_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IW'(in_req.entry_index)),
    .wr_x    (in_req.x_value),
    .wr_y    (in_req.y_value),
    .rd_addr (rd_idx_r),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  plk_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (arith_req),
    .div_num (diff),
    .div_den (dx),
    .mul_f   (arith_quot),
    .mul_dy  (dy_r),
    .done    (arith_done),
    .quot    (arith_quot),
    .prod    (arith_prod)
  );

  always_comb begin
    state_nxt       = state_r;
    entry_count_nxt = cfg_we ? cfg_wdata : entry_count_r;
    last_nxt        = last_r;
    rd_idx_nxt      = rd_idx_r;
    iss_done_nxt    = iss_done_r;
    chk_v_nxt       = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    match_nxt       = match_r;
    seg_nxt         = seg_r;
    qx_nxt          = qx_r;
    match_y_nxt     = match_y_r;
    prev_x_nxt      = prev_x_r;
    prev_y_nxt      = prev_y_r;
    xl_nxt          = xl_r;
    yl_nxt          = yl_r;
    xh_nxt          = xh_r;
    yh_nxt          = yh_r;
    dy_nxt          = dy_r;
    res_y_nxt       = res_y_r;
    res_region_nxt  = res_region_r;
    out_y_nxt       = out_y_r;
    out_region_nxt  = out_region_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    arith_req.start = 1'b0;
    arith_req.mode  = plk_pkg::AR_DIV;

    case (state_r)
      plk_pkg::ST_IDLE: begin
        if (in_acc && (in_req.op == plk_pkg::OP_QUERY)) begin
          qx_nxt = in_req.x_value;
          if (longint'(in_req.x_value) == plk_pkg::SENTINEL_X) begin
            res_y_nxt      = $signed(plk_pkg::ONE_FIXED);
            res_region_nxt = plk_pkg::REG_SENT;
            state_nxt      = plk_pkg::ST_FIN;
          end else begin
            last_nxt     = last_calc;
            rd_idx_nxt   = '0;
            iss_done_nxt = 1'b0;
            match_nxt    = 1'b0;
            seg_nxt      = 1'b0;
            state_nxt    = plk_pkg::ST_SCAN;
          end
        end
      end

      plk_pkg::ST_SCAN: begin
        // An address is issued in the cycle before its entry is checked.
        if (!iss_done_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = rd_idx_r;
          if (rd_idx_r == last_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (chk_v_r) begin
          prev_x_nxt = scan_x;
          prev_y_nxt = scan_y;
          if (!match_r && (qx_r == scan_x)) begin
            match_nxt   = 1'b1;
            match_y_nxt = scan_y;
          end
          // The segment is the first entry above x, paired with the one before it.
          if ((chk_idx_r != '0) && !seg_r && (qx_r < scan_x)) begin
            seg_nxt = 1'b1;
            xl_nxt  = prev_x_r;
            yl_nxt  = prev_y_r;
            xh_nxt  = scan_x;
            yh_nxt  = scan_y;
          end
          if ((chk_idx_r == '0) && (qx_r <= scan_x)) begin
            res_y_nxt      = scan_y;
            res_region_nxt = plk_pkg::REG_LOW;
            state_nxt      = plk_pkg::ST_FIN;
          end else if (chk_idx_r == last_r) begin
            if (qx_r >= scan_x) begin
              res_y_nxt      = scan_y;
              res_region_nxt = plk_pkg::REG_HIGH;
              state_nxt      = plk_pkg::ST_FIN;
            end else if (match_nxt) begin
              res_y_nxt      = match_y_nxt;
              res_region_nxt = plk_pkg::REG_EXACT;
              state_nxt      = plk_pkg::ST_FIN;
            end else begin
              state_nxt = plk_pkg::ST_PREP;
            end
          end
        end
      end

      plk_pkg::ST_PREP: begin
        res_region_nxt = plk_pkg::REG_INTERP;
        dy_nxt         = dy;
        // The fraction saturates at zero and one, so only the open interval divides.
        if (dx[DW] || (dx == '0) || diff[DW] || (diff == '0)) begin
          res_y_nxt = yl_r;
          state_nxt = plk_pkg::ST_FIN;
        end else if (diff >= dx) begin
          res_y_nxt = yh_r;
          state_nxt = plk_pkg::ST_FIN;
        end else begin
          arith_req.start = 1'b1;
          arith_req.mode  = plk_pkg::AR_DIV;
          state_nxt       = plk_pkg::ST_DIV;
        end
      end

      plk_pkg::ST_DIV: begin
        if (arith_done) begin
          arith_req.start = 1'b1;
          arith_req.mode  = plk_pkg::AR_MUL;
          state_nxt       = plk_pkg::ST_MUL;
        end
      end

      plk_pkg::ST_MUL: begin
        if (arith_done) begin
          res_y_nxt = yl_r + $signed(arith_prod[FW +: DW]);
          state_nxt = plk_pkg::ST_FIN;
        end
      end

      plk_pkg::ST_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_y_nxt      = res_y_r;
          out_region_nxt = res_region_r;
          state_nxt      = plk_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = plk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= plk_pkg::ST_IDLE;
      entry_count_r <= plk_pkg::CNT_W'(1);
      last_r        <= '0;
      rd_idx_r      <= '0;
      iss_done_r    <= 1'b1;
      chk_v_r       <= 1'b0;
      chk_idx_r     <= '0;
      match_r       <= 1'b0;
      seg_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      last_r        <= last_nxt;
      rd_idx_r      <= rd_idx_nxt;
      iss_done_r    <= iss_done_nxt;
      chk_v_r       <= chk_v_nxt;
      chk_idx_r     <= chk_idx_nxt;
      match_r       <= match_nxt;
      seg_r         <= seg_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qx_r         <= qx_nxt;
    match_y_r    <= match_y_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_y_r     <= prev_y_nxt;
    xl_r         <= xl_nxt;
    yl_r         <= yl_nxt;
    xh_r         <= xh_nxt;
    yh_r         <= yh_nxt;
    dy_r         <= dy_nxt;
    res_y_r      <= res_y_nxt;
    res_region_r <= res_region_nxt;
    out_y_r      <= out_y_nxt;
    out_region_r <= out_region_nxt;
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.y_result = out_y_r;
  assign out_rsp.region   = out_region_r;

endmodule

FILE: sv/plk_chk.sv
module plk_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input plk_pkg::op_t                        in_op,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [plk_pkg::DATA_W-1:0]   out_y,
  input plk_pkg::region_t                    out_region
);

  // A query holds the block busy for at least the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == plk_pkg::OP_QUERY)) |=> !in_ready)
    else $error("block ready right after a query request");

  // After a table write the block is ready again in the next cycle.
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == plk_pkg::OP_WRITE)) |=> in_ready)
    else $error("block not ready after a write request");

  // The sentinel answer is always exactly one.
  a_sent_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_region == plk_pkg::REG_SENT)) |->
      (out_y == $signed(plk_pkg::ONE_FIXED)))
    else $error("sentinel result is not one");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_y) && $stable(out_region)))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_lookup_top plk_chk u_plk_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .in_op      (in_req.op),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_y      (out_rsp.y_result),
  .out_region (out_rsp.region)
);

FILE: tb/sv/piecewise_linear_lookup_top_tb.sv
module piecewise_linear_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plk_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    op_t                      op;
    logic [IDX_IN_W-1:0]      entry_index;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
  } lookup_request_t;

  typedef struct {
    logic signed [DATA_W-1:0] y_result;
    region_t                  region;
  } lookup_answer_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  plk_in_if  in_req ();
  plk_out_if out_rsp ();

  piecewise_linear_lookup_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp)
  );

  lookup_request_t request_backlog[$];
  lookup_answer_t  awaited_answers[$];

  // Breakpoint table as the block holds it after each accepted request, and
  // the entry count as last configured.
  logic signed [DATA_W-1:0] bp_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] bp_y [TABLE_DEPTH];
  logic [CNT_W-1:0]         active_entries = 1;

  // Table contents as the stimulus will leave them, used to aim queries.
  logic signed [DATA_W-1:0] plan_x [TABLE_DEPTH];

  int   requests_taken = 0;
  int   queued_count = 0;
  int   mismatch_count = 0;
  logic hold_off = 1'b0;
  logic calm;

  assign calm = (requests_taken >= 300) && (requests_taken < 450);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic lookup_answer_t lookup_y(input logic signed [DATA_W-1:0] qx);
    lookup_answer_t r;
    int n;
    int i;
    longint xq, xl, yl, dx, dy, frac;
    n = (active_entries == 0) ? 1 :
        ((active_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_entries));
    xq = qx;
    r.y_result = '0;
    r.region = REG_INTERP;
    if (xq == SENTINEL_X) begin
      r.y_result = ONE_FIXED;
      r.region = REG_SENT;
      return r;
    end
    if (qx <= bp_x[0]) begin
      r.y_result = bp_y[0];
      r.region = REG_LOW;
      return r;
    end
    if (qx >= bp_x[n-1]) begin
      r.y_result = bp_y[n-1];
      r.region = REG_HIGH;
      return r;
    end
    for (i = 0; i < n; i++) begin
      if (bp_x[i] == qx) begin
        r.y_result = bp_y[i];
        r.region = REG_EXACT;
        return r;
      end
    end
    // The segment ends at the first slot above x; the last slot if none is.
    i = 1;
    while (i < n - 1 && qx >= bp_x[i]) i++;
    xl = bp_x[i-1];
    yl = bp_y[i-1];
    dx = longint'(bp_x[i]) - xl;
    dy = longint'(bp_y[i]) - yl;
    if (dx <= 0) begin
      r.y_result = yl[DATA_W-1:0];
    end else begin
      frac = ((xq - xl) <<< FRAC_BITS) / dx;
      if (frac < 0) frac = 0;
      if (frac > (64'sd1 <<< FRAC_BITS)) frac = 64'sd1 <<< FRAC_BITS;
      r.y_result = DATA_W'(yl + ((frac * dy) >>> FRAC_BITS));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_request_t req;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        requests_taken <= requests_taken + 1;
        if (in_req.op == OP_WRITE) begin
          bp_x[in_req.entry_index] = in_req.x_value;
          bp_y[in_req.entry_index] = in_req.y_value;
        end else begin
          awaited_answers.insert(awaited_answers.size(), lookup_y(in_req.x_value));
        end
      end
      if (!in_req.valid || in_req.ready) begin
        if (request_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          req = request_backlog.pop_front();
          in_req.valid <= 1'b1;
          in_req.op <= req.op;
          in_req.entry_index <= req.entry_index;
          in_req.x_value <= req.x_value;
          in_req.y_value <= req.y_value;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lookup_answer_t want;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (awaited_answers.size() == 0) begin
          mismatch_count++;
          $error("unexpected result: y_result %h, region %0d", out_rsp.y_result,
                 out_rsp.region);
        end else begin
          want = awaited_answers.pop_front();
          if (out_rsp.y_result !== want.y_result) begin
            mismatch_count++;
            $error("y_result: expected %h, actual %h", want.y_result, out_rsp.y_result);
          end
          if (out_rsp.region !== want.region) begin
            mismatch_count++;
            $error("region: expected %0d, actual %0d", want.region, out_rsp.region);
          end
        end
      end
      out_rsp.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 15);
    end
  end

  // One long stall of the result side, so that a finished answer sits in the
  // output register while the sender keeps offering requests.
  initial begin
    wait (requests_taken >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic queue_write(input int slot, input logic signed [DATA_W-1:0] xv,
                             input logic signed [DATA_W-1:0] yv);
    lookup_request_t req;
    req.op = OP_WRITE;
    req.entry_index = IDX_IN_W'(slot);
    req.x_value = xv;
    req.y_value = yv;
    plan_x[slot] = xv;
    request_backlog.insert(request_backlog.size(), req);
    queued_count++;
  endtask

  task automatic queue_query(input logic signed [DATA_W-1:0] xv);
    lookup_request_t req;
    req.op = OP_QUERY;
    req.entry_index = IDX_IN_W'($urandom_range(0, 63));
    req.x_value = xv;
    req.y_value = $urandom;
    request_backlog.insert(request_backlog.size(), req);
    queued_count++;
  endtask

  task automatic wait_for_idle();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_req.valid || awaited_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_count(input int value, output int n_used);
    wait_for_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    active_entries = CNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_used = (value == 0) ? 1 : ((value > TABLE_DEPTH) ? TABLE_DEPTH : value);
  endtask

  initial begin
    int n, k, kind, span_bits;
    longint steps [TABLE_DEPTH];
    longint total, room, base, lo, hi, xq;
    bit ascending;
    logic signed [DATA_W-1:0] yv;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.op = OP_WRITE;
    in_req.entry_index = '0;
    in_req.x_value = '0;
    in_req.y_value = '0;
    out_rsp.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single entry at reset count: sentinel, both clamps and the field extremes.
    queue_write(0, 32'sd0, 32'sh7FFF_FFFF);
    queue_query(DATA_W'(SENTINEL_X));
    queue_query(32'sh8000_0000);
    queue_query(32'sd0);
    queue_query(32'sh7FFF_FFFF);

    // A count of zero behaves as one entry.
    set_entry_count(0, n);
    queue_query(32'sd1);
    queue_query(-32'sd1);

    // Three entries with the widest possible y swing.
    set_entry_count(3, n);
    queue_write(0, -32'sh1_0000, 32'sh8000_0000);
    queue_write(1, 32'sd0, 32'sd0);
    queue_write(2, 32'sh2_0000, 32'sh7FFF_FFFF);
    queue_query(-32'sh1_0000);
    queue_query(-32'sh8000);
    queue_query(32'sd0);
    queue_query(32'sh1_0000);
    queue_query(32'sh1_FFFF);
    queue_query(32'sh2_0000);
    queue_query(DATA_W'(SENTINEL_X));

    // Middle entry above the last one: the table is no longer ascending.
    queue_write(1, 32'sh3_0000, 32'sh1234_5678);
    queue_query(32'sh1_8000);
    queue_query(32'sh2_8000);

    while (queued_count < 720) begin
      case ($urandom_range(0, 19))
        0:       set_entry_count(TABLE_DEPTH, n);
        1:       set_entry_count($urandom_range(65, 127), n);
        2:       set_entry_count(0, n);
        default: set_entry_count($urandom_range(1, 12), n);
      endcase

      ascending = ($urandom_range(0, 4) != 0);
      if (ascending) begin
        span_bits = $urandom_range(0, 25);
        total = 0;
        for (k = 1; k < n; k++) begin
          steps[k] = $urandom_range(1, 1 << span_bits);
          total += steps[k];
        end
        room = 64'h1_0000_0000 - total;
        base = -64'sd2147483648 + (longint'($urandom) % room);
        for (k = 0; k < n; k++) begin
          if (k > 0) base += steps[k];
          yv = ($urandom_range(0, 1) == 0) ? $urandom :
               DATA_W'(longint'($urandom_range(0, 32'h40000)) - 32'h20000);
          queue_write(k, DATA_W'(base), yv);
        end
      end else begin
        // Coarse x values so that repeats and descents are common.
        for (k = 0; k < n; k++)
          queue_write(k, DATA_W'(longint'($urandom_range(0, 31)) * 32'h4000 - 32'h40000),
                      $urandom);
      end

      repeat ($urandom_range(15, 40)) begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          // Rewrite a live slot at its own x, or load a slot outside the range.
          k = $urandom_range(0, 63);
          if (k < n) queue_write(k, plan_x[k], $urandom);
          else queue_write(k, $urandom, $urandom);
        end else if (kind < 25) begin
          queue_query(plan_x[$urandom_range(0, n - 1)]);
        end else if (kind < 60) begin
          xq = longint'($urandom) - 64'sd2147483648;
          if (n >= 2) begin
            k = $urandom_range(0, n - 2);
            lo = plan_x[k];
            hi = plan_x[k + 1];
            if (hi - lo > 1) xq = lo + 1 + (longint'($urandom) % (hi - lo - 1));
          end
          queue_query(DATA_W'(xq));
        end else if (kind < 70) begin
          xq = longint'(plan_x[0]) - $urandom_range(0, 1000);
          if (xq < -64'sd2147483648) xq = -64'sd2147483648;
          queue_query(DATA_W'(xq));
        end else if (kind < 80) begin
          xq = longint'(plan_x[n - 1]) + $urandom_range(0, 1000);
          if (xq > 64'sd2147483647) xq = 64'sd2147483647;
          queue_query(DATA_W'(xq));
        end else if (kind < 85) begin
          queue_query(DATA_W'(SENTINEL_X));
        end else begin
          queue_query($urandom);
        end
      end
    end

    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
